[rtl/core/bmpenc_pkg.sv]
// Shared types and codes for the bitmap pixel row encoder.
package bmpenc_pkg;

    // Output depth codes held in the format register.
    localparam logic [1:0] FMT_PAL4  = 2'd0;
    localparam logic [1:0] FMT_CUBE8 = 2'd1;
    localparam logic [1:0] FMT_RGB24 = 2'd2;

    // Reset value of the format register.
    localparam logic [1:0] FMT_RESET = FMT_RGB24;

    // Register indexes of the configuration port.
    localparam logic REG_PIXEL_FORMAT = 1'b0;

    // One byte-run command: the data bytes of a pixel and the row padding after them.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] n_data;
        logic [1:0] n_pad;
        logic       row_end;
    } t_cmd;

endpackage

[rtl/core/bmpenc_front.sv]
// Front end: accepts pixels, quantizes them and builds byte-run commands.
module bmpenc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_fmt,
    input  logic                 i_valid,
    input  logic [23:0]          i_pixel_rgb,
    input  logic                 i_row_end,
    input  logic                 i_queue_full,
    output logic                 o_accept,
    output logic                 o_push,
    output bmpenc_pkg::t_cmd     o_cmd
);
    import bmpenc_pkg::*;

    logic [3:0] r_held_nibble, n_held_nibble;
    logic       r_nibble_held, n_nibble_held;
    logic [1:0] r_phase, n_phase;

    logic [7:0] top_ch, mid_ch, low_ch;
    logic [9:0] sum3;
    logic       mid_gray;
    logic [3:0] pal_idx;
    logic [2:0] q_t, q_m, q_l;
    logic [7:0] cube_idx;
    logic [1:0] phase_after;
    logic [1:0] n_data;

    // Quotient by 51 of one channel byte, found by threshold compares.
    function automatic logic [2:0] div51(input logic [7:0] c);
        logic [2:0] q;
        q = 3'd0;
        if (c >= 8'd51)  q = 3'd1;
        if (c >= 8'd102) q = 3'd2;
        if (c >= 8'd153) q = 3'd3;
        if (c >= 8'd204) q = 3'd4;
        if (c == 8'd255) q = 3'd5;
        return q;
    endfunction

    assign top_ch = i_pixel_rgb[23:16];
    assign mid_ch = i_pixel_rgb[15:8];
    assign low_ch = i_pixel_rgb[7:0];

    // Sixteen-entry palette index; an average of 128 or more means a sum of 384 or more.
    always_comb begin
        sum3 = 10'(top_ch) + 10'(mid_ch) + 10'(low_ch);
        mid_gray = (top_ch > 8'd160) && (top_ch < 8'd224) &&
                   (mid_ch > 8'd160) && (mid_ch < 8'd224) &&
                   (low_ch > 8'd160) && (low_ch < 8'd224);
        if (mid_gray) begin
            pal_idx = 4'd8;
        end else if (sum3 >= 10'd384) begin
            pal_idx = {1'b1, top_ch[7], mid_ch[7], low_ch[7]};
        end else begin
            pal_idx = {1'b0, |top_ch[7:6], |mid_ch[7:6], |low_ch[7:6]};
        end
    end

    // Six-level color cube index.
    always_comb begin
        q_t = div51(top_ch);
        q_m = div51(mid_ch);
        q_l = div51(low_ch);
        cube_idx = 8'(8'd36 * {5'd0, q_t}) + 8'(8'd6 * {5'd0, q_m}) + {5'd0, q_l};
    end

    // Command build and nibble/phase bookkeeping.
    always_comb begin
        n_held_nibble = r_held_nibble;
        n_nibble_held = r_nibble_held;
        n_data        = 2'd0;
        o_cmd         = '0;
        o_cmd.row_end = i_row_end;
        unique case (i_fmt)
            FMT_PAL4: begin
                if (r_nibble_held) begin
                    o_cmd.byte0   = {r_held_nibble, pal_idx};
                    n_data        = 2'd1;
                    n_nibble_held = 1'b0;
                end else if (i_row_end) begin
                    o_cmd.byte0 = {pal_idx, 4'd0};
                    n_data      = 2'd1;
                end else begin
                    n_held_nibble = pal_idx;
                    n_nibble_held = 1'b1;
                end
            end
            FMT_CUBE8: begin
                o_cmd.byte0   = cube_idx;
                n_data        = 2'd1;
                n_nibble_held = 1'b0;
            end
            default: begin
                o_cmd.byte0   = top_ch;
                o_cmd.byte1   = mid_ch;
                o_cmd.byte2   = low_ch;
                n_data        = 2'd3;
                n_nibble_held = 1'b0;
            end
        endcase
        phase_after  = r_phase + n_data;
        o_cmd.n_data = n_data;
        if (i_row_end) begin
            n_nibble_held = 1'b0;
            o_cmd.n_pad   = 2'd0 - phase_after;
            n_phase       = 2'd0;
        end else begin
            n_phase = phase_after;
        end
    end

    assign o_accept = i_valid && !i_queue_full;
    assign o_push   = o_accept && (n_data != 2'd0);

    // State registers move only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_nibble <= 4'd0;
            r_nibble_held <= 1'b0;
            r_phase       <= 2'd0;
        end else if (o_accept) begin
            r_held_nibble <= n_held_nibble;
            r_nibble_held <= n_nibble_held;
            r_phase       <= n_phase;
        end
    end

endmodule

[rtl/core/bmpenc_queue.sv]
// Two-entry command queue between the front end and the byte sender.
module bmpenc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bmpenc_pkg::t_cmd     i_cmd,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output bmpenc_pkg::t_cmd     o_cmd
);
    import bmpenc_pkg::*;

    // Entry 0 is always the head; entry 1 shifts down on a pop.
    t_cmd r_ent0, r_ent1;
    logic r_v0, r_v1;

    assign o_full  = r_v1;
    assign o_valid = r_v0;
    assign o_cmd   = r_ent0;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            unique case ({i_push, i_pop})
                2'b01: begin
                    r_v0 <= r_v1;
                    r_v1 <= 1'b0;
                end
                2'b10: begin
                    r_v0 <= 1'b1;
                    r_v1 <= r_v0;
                end
                default: begin
                    r_v0 <= r_v0;
                    r_v1 <= r_v1;
                end
            endcase
        end
    end

    // Payload entries.
    always_ff @(posedge i_clk) begin
        unique case ({i_push, i_pop})
            2'b11: begin
                if (r_v1) begin
                    r_ent0 <= r_ent1;
                    r_ent1 <= i_cmd;
                end else begin
                    r_ent0 <= i_cmd;
                end
            end
            2'b01: begin
                r_ent0 <= r_ent1;
            end
            2'b10: begin
                if (r_v0) begin
                    r_ent1 <= i_cmd;
                end else begin
                    r_ent0 <= i_cmd;
                end
            end
            default: begin
                r_ent0 <= r_ent0;
                r_ent1 <= r_ent1;
            end
        endcase
    end

endmodule

[rtl/core/bmpenc_back.sv]
// Back end: expands commands to bytes in the output register, one per cycle unless stalled.
module bmpenc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  bmpenc_pkg::t_cmd     i_cmd,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_row_done,
    output logic                 o_run_last
);
    import bmpenc_pkg::*;

    logic [2:0] r_k;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_row_done;
    logic       r_run_last;

    logic       load;
    logic       is_last;
    logic [2:0] last_k;
    logic [7:0] cur_byte;

    // Pick the byte at position r_k: data bytes first, then zero padding.
    always_comb begin
        last_k = 3'(i_cmd.n_data) + 3'(i_cmd.n_pad) - 3'd1;
        is_last = (r_k == last_k);
        if (r_k >= 3'(i_cmd.n_data)) begin
            cur_byte = 8'd0;
        end else begin
            unique case (r_k[1:0])
                2'd0:    cur_byte = i_cmd.byte0;
                2'd1:    cur_byte = i_cmd.byte1;
                default: cur_byte = i_cmd.byte2;
            endcase
        end
    end

    assign load  = i_cmd_valid && (!r_valid || !i_stall);
    assign o_pop = load && is_last;

    // Byte counter within the head command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 3'd0;
        end else if (load) begin
            r_k <= is_last ? 3'd0 : r_k + 3'd1;
        end
    end

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= cur_byte;
            r_row_done <= is_last && i_cmd.row_end;
            r_run_last <= is_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_row_done = r_row_done;
    assign o_run_last = r_run_last;

endmodule

[rtl/core/bmp_pixel_row_encoder.sv]
// Top level of the bitmap pixel row encoder with its configuration register.
//
// Channel   Direction  Handshake           Payload
// pixel     in         i_valid / o_stall   i_pixel_rgb, i_row_end
// bytes     out        o_valid / i_stall   o_out_byte, o_row_done, o_run_last
// config    in         APB write/read      pixel_format at byte address 0
//
// The byte sender puts out one byte per cycle while the output is not stalled; a pixel
// causes three bytes in 24-bit mode, one in 8-bit mode, one per two pixels in 4-bit mode,
// plus up to three padding bytes at a row end.
// A pixel's bytes pass through the queue and then the output register.
// Reset is synchronous and active low; it empties the queue and sets 24-bit mode.
// A stalled output holds its byte; the two-entry queue lets pixels keep arriving until it is full.
module bmp_pixel_row_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_pixel_rgb,
    input  logic        i_row_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_row_done,
    output logic        o_run_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bmpenc_pkg::*;

    logic [1:0] r_fmt;
    logic       q_full;
    logic       q_valid;
    logic       f_accept;
    logic       f_push;
    logic       b_pop;
    t_cmd       f_cmd;
    t_cmd       q_cmd;

    // Configuration register.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_PIXEL_FORMAT)) begin
            r_fmt <= pwdata[1:0];
        end
    end

    // Read-back.
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_PIXEL_FORMAT) begin
            prdata = {30'd0, r_fmt};
        end
    end

    assign o_stall = q_full;

    bmpenc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fmt        (r_fmt),
        .i_valid      (i_valid),
        .i_pixel_rgb  (i_pixel_rgb),
        .i_row_end    (i_row_end),
        .i_queue_full (q_full),
        .o_accept     (f_accept),
        .o_push       (f_push),
        .o_cmd        (f_cmd)
    );

    bmpenc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push && f_accept),
        .i_cmd   (f_cmd),
        .i_pop   (b_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    bmpenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (b_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_row_done  (o_row_done),
        .o_run_last  (o_run_last)
    );

endmodule

[sim/tb_bmp_pixel_row_encoder.sv]
// Self-checking testbench for the bitmap pixel row encoder: directed table, then random rows.
module tb_bmp_pixel_row_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import bmpenc_pkg::*;

    // Byte address of the format register.
    localparam logic [2:0] FMT_ADDR = {REG_PIXEL_FORMAT, 2'b00};
    // Cycles allowed for a pixel that makes no byte to settle before a register write.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_PIXELS  = 32;
    localparam int NUM_PHASES    = 8;
    localparam int HOLD_CYCLES   = 80;

    typedef enum logic {ROW_PIXEL, ROW_FORMAT} t_row_kind;

    // One row of the directed table; typed_n < 0 means the predictor supplies the bytes.
    typedef struct {
        t_row_kind   kind;
        logic [23:0] rgb;
        logic        row_end;
        logic [1:0]  fmt;
        int          typed_n;
        logic [47:0] typed_bytes;
    } t_dir_row;

    // One expected output byte with its flags.
    typedef struct {
        logic [7:0] val;
        logic       done;
        logic       last;
    } t_byte_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [23:0] i_pixel_rgb;
    logic        i_row_end;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_row_done;
    logic        o_run_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: format register, held palette nibble and row byte phase.
    logic [1:0]  fmt_q;
    logic [3:0]  held_q;
    logic        held_v;
    logic [1:0]  phase_q;

    logic [7:0]  enc_bytes[$];
    t_byte_exp   row_bytes_q[$];
    t_dir_row    dir_rows[$];

    int          err_count = 0;
    int          bytes_checked = 0;
    int          pixels_sent = 0;
    int          fmt_writes = 0;
    bit          calm_tx = 1'b0;
    bit          calm_rx = 1'b0;
    int          hold_len = 0;

    bmp_pixel_row_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_rgb (i_pixel_rgb),
        .i_row_end   (i_row_end),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_row_done  (o_row_done),
        .o_run_last  (o_run_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Append one byte to the predicted run and advance the row phase.
    function automatic void emit(input logic [7:0] b);
        enc_bytes.push_back(b);
        phase_q = phase_q + 2'd1;
    endfunction

    // Work out the bytes that one pixel causes, updating the predictor state.
    function automatic void encode_pixel(input logic [23:0] rgb, input logic re);
        int t;
        int m;
        int l;
        int avg;
        logic [3:0] idx;
        t = int'(rgb[23:16]);
        m = int'(rgb[15:8]);
        l = int'(rgb[7:0]);
        enc_bytes.delete();
        if (fmt_q == FMT_PAL4) begin
            // Mid-gray band first, then bright or dark palette halves.
            avg = (t + m + l) / 3;
            if (t > 160 && t < 224 && m > 160 && m < 224 && l > 160 && l < 224) begin
                idx = 4'd8;
            end else if (avg >= 128) begin
                idx = {1'b1, rgb[23], rgb[15], rgb[7]};
            end else begin
                idx = {1'b0, t >= 64, m >= 64, l >= 64};
            end
            if (held_v) begin
                emit({held_q, idx});
                held_v = 1'b0;
            end else if (re) begin
                emit({idx, 4'h0});
            end else begin
                held_q = idx;
                held_v = 1'b1;
            end
        end else if (fmt_q == FMT_CUBE8) begin
            held_v = 1'b0;
            emit(8'(36 * (t / 51) + 6 * (m / 51) + l / 51));
        end else begin
            // Twenty-four-bit mode, also taken for format code three.
            held_v = 1'b0;
            emit(rgb[23:16]);
            emit(rgb[15:8]);
            emit(rgb[7:0]);
        end
        // Row end drops any held nibble and pads to a four-byte boundary.
        if (re) begin
            held_v = 1'b0;
            while (phase_q != 2'd0) emit(8'h00);
        end
    endfunction

    // Offer one pixel request, wait for acceptance and queue its expected bytes.
    task automatic send_pixel(input logic [23:0] rgb, input logic re, input int typed_n,
                              input logic [47:0] typed_bytes);
        int gap;
        t_byte_exp e;
        gap = calm_tx ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pixel_rgb <= rgb;
        i_row_end   <= re;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        encode_pixel(rgb, re);
        if (typed_n >= 0) begin
            enc_bytes.delete();
            for (int k = 0; k < typed_n; k++) enc_bytes.push_back(typed_bytes[47 - 8 * k -: 8]);
        end
        for (int k = 0; k < enc_bytes.size(); k++) begin
            e.val  = enc_bytes[k];
            e.last = (k == enc_bytes.size() - 1);
            e.done = e.last && re;
            row_bytes_q.push_back(e);
        end
        pixels_sent++;
    endtask

    // Drop valid, let every expected byte drain and give the block time to settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (row_bytes_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the format register over APB, then read it back.
    task automatic write_format(input logic [1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FMT_ADDR;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {30'd0, v}) report_mismatch("format readback", prdata, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        fmt_q = v;
        fmt_writes++;
    endtask

    // Pick one channel value, leaning on the thresholds of the quantizers.
    function automatic logic [7:0] pick_channel(input bit band);
        logic [7:0] edges[12] = '{0, 50, 51, 63, 64, 127, 128, 160, 161, 223, 224, 255};
        if (band) return 8'($urandom_range(161, 223));
        case ($urandom_range(0, 3))
            0: return edges[$urandom_range(0, 11)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Receiver: random hold-offs per byte, plus one long hold-off on request.
    initial begin
        int rx_gap;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                i_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                rx_gap = 0;
            end else begin
                rx_gap = calm_rx ? 0 : $urandom_range(0, 13);
            end
            if (rx_gap > 0) begin
                i_stall <= 1'b1;
                repeat (rx_gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Compare every accepted byte with the oldest expectation.
    always @(posedge i_clk) begin : check_bytes
        t_byte_exp want;
        if (i_rst_n === 1'b1 && o_valid && !i_stall) begin
            if (row_bytes_q.size() == 0) begin
                report_mismatch("unexpected byte", o_out_byte, 0);
            end else begin
                want = row_bytes_q.pop_front();
                if (o_out_byte !== want.val) report_mismatch("out_byte", o_out_byte, want.val);
                if (o_row_done !== want.done) report_mismatch("row_done", o_row_done, want.done);
                if (o_run_last !== want.last) report_mismatch("run_last", o_run_last, want.last);
                bytes_checked++;
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("bmp_pixel_row_encoder regression: fail");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial begin
        logic [1:0]  phase_fmt[NUM_PHASES] = '{FMT_PAL4, FMT_CUBE8, FMT_RGB24, FMT_PAL4,
                                                2'd3, FMT_RGB24, FMT_PAL4, FMT_CUBE8};
        logic [23:0] rgb;
        logic        re;
        bit          noise;
        bit          band;
        int          sent;
        int          row_len;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_pixel_rgb = '0;
        i_row_end   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        fmt_q       = FMT_RESET;
        held_q      = '0;
        held_v      = 1'b0;
        phase_q     = '0;

        // Directed table: reset mode extremes, cube extremes, palette cases, format changes.
        dir_rows.push_back('{ROW_PIXEL,  24'h123456, 1'b0, FMT_RGB24, 3, 48'h123456_000000});
        dir_rows.push_back('{ROW_PIXEL,  24'hFFFFFF, 1'b1, FMT_RGB24, 5, 48'hFFFFFF_000000});
        dir_rows.push_back('{ROW_PIXEL,  24'h000000, 1'b1, FMT_RGB24, 4, 48'h0});
        dir_rows.push_back('{ROW_FORMAT, 24'h0,      1'b0, FMT_CUBE8, -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'hFFFFFF, 1'b0, FMT_CUBE8, 1, 48'hD70000_000000});
        dir_rows.push_back('{ROW_PIXEL,  24'h000000, 1'b1, FMT_CUBE8, 3, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'h323366, 1'b1, FMT_CUBE8, -1, 48'h0});
        dir_rows.push_back('{ROW_FORMAT, 24'h0,      1'b0, FMT_PAL4,  -1, 48'h0});
        // A lone bright nibble is held and makes no byte.
        dir_rows.push_back('{ROW_PIXEL,  24'hFFFFFF, 1'b0, FMT_PAL4,  0, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'h000000, 1'b0, FMT_PAL4,  1, 48'hF00000_000000});
        // Gray band with a row end and nothing held: lone nibble goes high, then padding.
        dir_rows.push_back('{ROW_PIXEL,  24'hC8C8C8, 1'b1, FMT_PAL4,  3, 48'h800000_000000});
        dir_rows.push_back('{ROW_PIXEL,  24'hA1DFA1, 1'b0, FMT_PAL4,  -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'hA0C8C8, 1'b0, FMT_PAL4,  -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'h7F8080, 1'b1, FMT_PAL4,  -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'h404040, 1'b0, FMT_PAL4,  -1, 48'h0});
        // Format change while a nibble is held: the cube pixel drops it.
        dir_rows.push_back('{ROW_FORMAT, 24'h0,      1'b0, FMT_CUBE8, -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'h333333, 1'b0, FMT_CUBE8, -1, 48'h0});
        dir_rows.push_back('{ROW_FORMAT, 24'h0,      1'b0, FMT_PAL4,  -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'h3F3F3F, 1'b1, FMT_PAL4,  -1, 48'h0});
        // Format code three behaves as twenty-four-bit mode.
        dir_rows.push_back('{ROW_FORMAT, 24'h0,      1'b0, 2'd3,      -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'hABCDEF, 1'b1, 2'd3,      -1, 48'h0});
        dir_rows.push_back('{ROW_FORMAT, 24'h0,      1'b0, FMT_PAL4,  -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'h010203, 1'b0, FMT_PAL4,  -1, 48'h0});
        dir_rows.push_back('{ROW_FORMAT, 24'h0,      1'b0, FMT_RGB24, -1, 48'h0});
        dir_rows.push_back('{ROW_PIXEL,  24'hE0E0E0, 1'b1, FMT_RGB24, -1, 48'h0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_FORMAT) begin
                wait_idle();
                write_format(dir_rows[r].fmt);
            end else begin
                send_pixel(dir_rows[r].rgb, dir_rows[r].row_end, dir_rows[r].typed_n,
                           dir_rows[r].typed_bytes);
            end
        end

        // Random phases: mostly well-formed rows, some noisy row ends.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_format(phase_fmt[p]);
            calm_tx = (p == 2) || (p == 5);
            calm_rx = (p == 2);
            // Long receiver hold-off while pixels keep coming, to fill the block.
            if (p == 5) hold_len = HOLD_CYCLES;
            sent = 0;
            while (sent < PHASE_PIXELS) begin
                row_len = $urandom_range(1, 9);
                noise = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < row_len && sent < PHASE_PIXELS; k++) begin
                    band = ($urandom_range(0, 4) == 0);
                    rgb = {pick_channel(band), pick_channel(band), pick_channel(band)};
                    re = noise ? 1'($urandom_range(0, 1)) : (k == row_len - 1);
                    send_pixel(rgb, re, -1, 48'h0);
                    sent++;
                end
            end
        end

        // Drain and let any trailing work finish.
        i_valid <= 1'b0;
        calm_rx = 1'b0;
        while (row_bytes_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (row_bytes_q.size() != 0) report_mismatch("bytes never sent", 0, row_bytes_q.size());

        $display("Run covered %0d pixels and %0d checked bytes over %0d format writes,",
                 pixels_sent, bytes_checked, fmt_writes);
        $display("all three depths plus code three, held nibbles, padding and a stalled input.");
        if (err_count == 0) begin
            $display("bmp_pixel_row_encoder regression: pass");
        end else begin
            $display("bmp_pixel_row_encoder regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/bmpenc_pkg.sv
rtl/core/bmpenc_front.sv
rtl/core/bmpenc_queue.sv
rtl/core/bmpenc_back.sv
rtl/core/bmp_pixel_row_encoder.sv
sim/tb_bmp_pixel_row_encoder.sv
